@@ hw/rtl/ptad_pkg.sv @@
`timescale 1ns / 1ps
package ptad_pkg;

   typedef logic [2:0][31:0] vec3_type;

   localparam int SQRT_STEPS   = 31;
   localparam int DIV_STEPS    = 31;
   localparam int CORDIC_STEPS = 30;

   localparam logic [22:0] RADIUS_RESET = 23'd4053770;
   localparam logic [31:0] ANG_PI       = 32'd3373259426;
   localparam logic [31:0] ANG_HALF_PI  = 32'd1686629713;
   localparam logic [23:0] DIST_MAX     = 24'hFFFFFF;

   localparam logic [30:0] ATAN_TABLE [CORDIC_STEPS] = '{
      31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
      31'd33543515,  31'd16775850,  31'd8388437,   31'd4194282,   31'd2097149,
      31'd1048575,   31'd524287,    31'd262143,    31'd131071,    31'd65535,
      31'd32767,     31'd16383,     31'd8191,      31'd4095,      31'd2047,
      31'd1023,      31'd511,       31'd255,       31'd127,       31'd63,
      31'd31,        31'd15,        31'd7,         31'd3,         31'd1
   };

   typedef struct packed {
      logic [33:0] rem;
      logic [31:0] root;
      logic [61:0] val;
   } sqrt_type;

   typedef struct packed {
      logic [32:0] rem;
      logic [30:0] quo;
      logic [30:0] low;
   } div_type;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [32:0] z;
   } cordic_type;

   typedef struct packed {
      logic [2:0][29:0] m;
      logic             zero;
      logic [2:0]       sgn;
   } uc_tag_type;

   typedef struct packed {
      vec3_type p;
      vec3_type a;
      vec3_type b;
   } query_type;

   typedef struct packed {
      query_type q;
      vec3_type  g;
      logic      degen;
   } stage2_side_type;

   typedef struct packed {
      query_type q;
      logic      degen;
   } stage3_side_type;

   typedef struct packed {
      vec3_type t;
      logic     on_arc;
      logic     degen;
   } ac_side_type;

   // one digit of a square root, two radicand bits per step
   function automatic sqrt_type sqrt_step(sqrt_type s);
      sqrt_type    r;
      logic [33:0] acc;
      logic [33:0] trial;
      acc   = {s.rem[31:0], s.val[61:60]};
      trial = {s.root, 2'b01};
      r.val = {s.val[59:0], 2'b00};
      if (acc >= trial) begin
         r.rem  = acc - trial;
         r.root = {s.root[30:0], 1'b1};
      end else begin
         r.rem  = acc;
         r.root = {s.root[30:0], 1'b0};
      end
      return r;
   endfunction

   // one quotient bit of a restoring division
   function automatic div_type div_step(div_type s, logic [31:0] n);
      div_type     r;
      logic [32:0] acc;
      acc   = {s.rem[31:0], s.low[30]};
      r.low = {s.low[29:0], 1'b0};
      if (acc >= {1'b0, n}) begin
         r.rem = acc - {1'b0, n};
         r.quo = {s.quo[29:0], 1'b1};
      end else begin
         r.rem = acc;
         r.quo = {s.quo[29:0], 1'b0};
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/ptad_unit_cross.sv @@
`timescale 1ns / 1ps
module ptad_unit_cross #(
   parameter int FRACTION_BITS = 30,
   parameter int SIDE_W        = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  ptad_pkg::vec3_type       a,
   input  ptad_pkg::vec3_type       b,
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_valid,
   output ptad_pkg::vec3_type       u,
   output logic                     zero,
   output logic [SIDE_W-1:0]        out_side
);

   localparam int SQ  = ptad_pkg::SQRT_STEPS;
   localparam int DV  = ptad_pkg::DIV_STEPS;
   localparam int LAT = 7 + SQ + 1 + DV + 1;

   logic [LAT-1:0]    valid_ff;
   logic [SIDE_W-1:0] side_ff [LAT];

   logic signed [63:0] prod_in  [6];
   logic signed [63:0] prod_ff  [6];
   logic signed [64:0] cross_in [3];
   logic signed [64:0] cross_ff [3];
   logic [64:0]        mag_in   [3];
   logic [64:0]        mag_ff   [3];
   logic [2:0]         sgn_in;
   logic [2:0]         sgn_ff;
   logic [64:0]        mag4_ff  [3];
   logic [2:0]         sgn4_ff;
   logic [64:0]        any_in;
   logic [6:0]         pos_in;
   logic [6:0]         pos_ff;
   logic               zero4_ff;
   logic [64:0]        sh_in    [3];
   ptad_pkg::uc_tag_type tag5_in;
   ptad_pkg::uc_tag_type tag5_ff;
   ptad_pkg::uc_tag_type tag6_ff;
   logic [59:0]        sq6_ff   [3];
   ptad_pkg::sqrt_type   sq_in;
   ptad_pkg::sqrt_type   sq_ff  [SQ+1];
   ptad_pkg::uc_tag_type tag_ff [SQ+1];
   logic [60:0]        num_in   [3];
   ptad_pkg::div_type    dv_in  [3];
   ptad_pkg::div_type    dv_ff  [DV+1][3];
   logic [31:0]        n_ff     [DV+1];
   logic [3:0]         dz_ff    [DV+1];
   ptad_pkg::vec3_type   u_in;
   ptad_pkg::vec3_type   u_ff;
   logic               zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // cross product terms, then differences, then magnitudes
   always_comb begin
      prod_in[0] = $signed(a[1]) * $signed(b[2]);
      prod_in[1] = $signed(a[2]) * $signed(b[1]);
      prod_in[2] = $signed(a[2]) * $signed(b[0]);
      prod_in[3] = $signed(a[0]) * $signed(b[2]);
      prod_in[4] = $signed(a[0]) * $signed(b[1]);
      prod_in[5] = $signed(a[1]) * $signed(b[0]);
      for (int i = 0; i < 3; i++) begin
         cross_in[i] = 65'(prod_ff[2*i]) - 65'(prod_ff[2*i+1]);
         sgn_in[i]   = cross_ff[i][64];
         mag_in[i]   = cross_ff[i][64] ? 65'(-cross_ff[i]) : 65'(cross_ff[i]);
      end
   end

   // leading one of the or of the magnitudes is that of the largest
   always_comb begin
      any_in = mag_ff[0] | mag_ff[1] | mag_ff[2];
      pos_in = '0;
      for (int i = 0; i < 65; i++) begin
         if (any_in[i]) begin
            pos_in = 7'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (pos_ff >= 7'd30) begin
            sh_in[i] = mag4_ff[i] >> (pos_ff - 7'd29);
         end else begin
            sh_in[i] = mag4_ff[i] << (7'd29 - pos_ff);
         end
         tag5_in.m[i] = sh_in[i][29:0];
      end
      tag5_in.zero = zero4_ff;
      tag5_in.sgn  = sgn4_ff;
      sq_in.rem  = '0;
      sq_in.root = '0;
      sq_in.val  = 62'(sq6_ff[0]) + 62'(sq6_ff[1]) + 62'(sq6_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= prod_in;
         cross_ff  <= cross_in;
         mag_ff    <= mag_in;
         sgn_ff    <= sgn_in;
         mag4_ff   <= mag_ff;
         sgn4_ff   <= sgn_ff;
         pos_ff    <= pos_in;
         zero4_ff  <= (any_in == '0);
         tag5_ff   <= tag5_in;
         tag6_ff   <= tag5_ff;
         for (int i = 0; i < 3; i++) begin
            sq6_ff[i] <= tag5_ff.m[i] * tag5_ff.m[i];
         end
         sq_ff[0]  <= sq_in;
         tag_ff[0] <= tag6_ff;
      end
   end

   for (genvar k = 1; k <= SQ; k++) begin : g_sqrt
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[k]  <= ptad_pkg::sqrt_step(sq_ff[k-1]);
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   // numerator m * 2^fb + n/2, the quotient stays below 2^31
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = (61'(tag_ff[SQ].m[i]) << FRACTION_BITS)
                   + 61'(sq_ff[SQ].root >> 1);
         dv_in[i].rem = {3'b000, num_in[i][60:31]};
         dv_in[i].quo = '0;
         dv_in[i].low = num_in[i][30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[0] <= dv_in;
         n_ff[0]  <= sq_ff[SQ].root;
         dz_ff[0] <= {tag_ff[SQ].zero, tag_ff[SQ].sgn};
      end
   end

   for (genvar k = 1; k <= DV; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               dv_ff[k][i] <= ptad_pkg::div_step(dv_ff[k-1][i], n_ff[k-1]);
            end
            n_ff[k]  <= n_ff[k-1];
            dz_ff[k] <= dz_ff[k-1];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u_in[i] = dz_ff[DV][i] ? -{1'b0, dv_ff[DV][i].quo} : {1'b0, dv_ff[DV][i].quo};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff    <= u_in;
         zero_ff <= dz_ff[DV][3];
      end
   end

   assign out_valid = valid_ff[LAT-1];
   assign out_side  = side_ff[LAT-1];
   assign u         = u_ff;
   assign zero      = zero_ff;

endmodule

@@ hw/rtl/ptad_arccos.sv @@
`timescale 1ns / 1ps
module ptad_arccos #(
   parameter int FRACTION_BITS = 30,
   parameter int SIDE_W        = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [31:0] cosine,
   input  logic [SIDE_W-1:0]  in_side,
   output logic               out_valid,
   output logic [31:0]        angle,
   output logic [SIDE_W-1:0]  out_side
);

   localparam int SQ  = ptad_pkg::SQRT_STEPS;
   localparam int CS  = ptad_pkg::CORDIC_STEPS;
   localparam int LAT = 3 + SQ + CS + 1;
   localparam int UP  = 30 - FRACTION_BITS;
   localparam logic [61:0] ONE2 = 62'd1 << (2 * FRACTION_BITS);

   logic [LAT-1:0]    valid_ff;
   logic [SIDE_W-1:0] side_ff [LAT];

   logic [31:0]          mag1_ff;
   logic                 neg1_ff;
   logic [61:0]          sq2_ff;
   logic [31:0]          x2_ff;
   logic                 neg2_ff;
   ptad_pkg::sqrt_type   sq_in;
   ptad_pkg::sqrt_type   sq_ff [SQ+1];
   logic [31:0]          xq_ff [SQ+1];
   logic                 nq_ff [SQ+1];
   ptad_pkg::cordic_type cd_in;
   ptad_pkg::cordic_type cd_ff [CS];
   logic                 cn_ff [CS];
   logic signed [32:0]   z_fin;
   logic [31:0]          zc_in;
   logic [31:0]          angle_in;
   logic [31:0]          angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   always_comb begin
      sq_in.rem  = '0;
      sq_in.root = '0;
      sq_in.val  = ONE2 - sq2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff  <= cosine[31] ? 32'(-cosine) : 32'(cosine);
         neg1_ff  <= cosine[31];
         sq2_ff   <= mag1_ff[30:0] * mag1_ff[30:0];
         x2_ff    <= mag1_ff << UP;
         neg2_ff  <= neg1_ff;
         sq_ff[0] <= sq_in;
         xq_ff[0] <= x2_ff;
         nq_ff[0] <= neg2_ff;
      end
   end

   for (genvar k = 1; k <= SQ; k++) begin : g_sqrt
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[k] <= ptad_pkg::sqrt_step(sq_ff[k-1]);
            xq_ff[k] <= xq_ff[k-1];
            nq_ff[k] <= nq_ff[k-1];
         end
      end
   end

   always_comb begin
      cd_in.x = $signed({2'b00, xq_ff[SQ]});
      cd_in.y = $signed({2'b00, sq_ff[SQ].root << UP});
      cd_in.z = '0;
   end

   // vectoring rotations, one per stage
   for (genvar k = 0; k < CS; k++) begin : g_cordic
      ptad_pkg::cordic_type src;
      ptad_pkg::cordic_type nxt_in;
      logic                 ns;
      logic signed [33:0]   xs;
      logic signed [33:0]   ys;
      logic signed [32:0]   at;
      if (k == 0) begin : g_first
         assign src = cd_in;
         assign ns  = nq_ff[SQ];
      end else begin : g_rest
         assign src = cd_ff[k-1];
         assign ns  = cn_ff[k-1];
      end
      always_comb begin
         xs = src.x >>> k;
         ys = src.y >>> k;
         at = $signed({2'b00, ptad_pkg::ATAN_TABLE[k]});
         if (!src.y[33]) begin
            nxt_in.x = src.x + ys;
            nxt_in.y = src.y - xs;
            nxt_in.z = src.z + at;
         end else begin
            nxt_in.x = src.x - ys;
            nxt_in.y = src.y + xs;
            nxt_in.z = src.z - at;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            cd_ff[k] <= nxt_in;
            cn_ff[k] <= ns;
         end
      end
   end

   always_comb begin
      z_fin = cd_ff[CS-1].z;
      if (z_fin[32]) begin
         zc_in = '0;
      end else if (z_fin > $signed({1'b0, ptad_pkg::ANG_HALF_PI})) begin
         zc_in = ptad_pkg::ANG_HALF_PI;
      end else begin
         zc_in = z_fin[31:0];
      end
      angle_in = cn_ff[CS-1] ? ptad_pkg::ANG_PI - zc_in : zc_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
      end
   end

   assign out_valid = valid_ff[LAT-1];
   assign out_side  = side_ff[LAT-1];
   assign angle     = angle_ff;

endmodule

@@ hw/rtl/point_to_arc_distance.sv @@
`timescale 1ns / 1ps
// Cross-track distance from a query point to the great circle through two segment ends,
// all given as unit vectors in signed fixed point. The result carries the distance in
// 1/1024 mile (saturated), the nearest point on the circle, a flag for whether that point
// lies between the ends, and an error flag when a cross product has zero length. The unit
// is fully pipelined and takes one transaction per clock while no result is held; each result
// passes through three normalized cross products (square root and divider of 31 steps each),
// four dot-product stages and an arccos built from a square root and 30 rotation steps.
// A stalled result holds the whole pipeline, so requests are stalled while it waits. The
// user must write the radius register only when the pipeline is empty; the block itself
// does not enforce this.
module point_to_arc_distance #(
   parameter int FRACTION_BITS = 30
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_start_z,
   input  logic signed [31:0] req_end_x,
   input  logic signed [31:0] req_end_y,
   input  logic signed [31:0] req_end_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [23:0]        rsp_distance,
   output logic               rsp_within_segment,
   output logic signed [31:0] rsp_nearest_x,
   output logic signed [31:0] rsp_nearest_y,
   output logic signed [31:0] rsp_nearest_z,
   output logic               rsp_degenerate,
   input  logic               csr_wr_en,
   input  logic [22:0]        csr_wr_data
);

   localparam logic signed [65:0] DOT_LIM = 66'sd1 <<< (2 * FRACTION_BITS);

   logic en;
   logic [22:0] radius_ff;

   ptad_pkg::query_type       q_in;
   logic                      v1;
   ptad_pkg::vec3_type        g1;
   logic                      z1;
   ptad_pkg::query_type       s1;
   ptad_pkg::stage2_side_type s2_in;
   logic                      v2;
   ptad_pkg::vec3_type        f2;
   logic                      z2;
   ptad_pkg::stage2_side_type s2;
   ptad_pkg::stage3_side_type s3_in;
   logic                      v3;
   ptad_pkg::vec3_type        t3;
   logic                      z3;
   ptad_pkg::stage3_side_type s3;

   logic                      dv1_ff;
   logic signed [63:0]        dp_in [12];
   logic signed [63:0]        dp_ff [12];
   ptad_pkg::vec3_type        t1_ff;
   logic                      dg1_ff;
   logic                      dv2_ff;
   logic signed [65:0]        ds_ff [4];
   ptad_pkg::vec3_type        t2_ff;
   logic                      dg2_ff;
   logic                      dv3_ff;
   logic signed [61:0]        dc_in [4];
   logic signed [61:0]        dc_ff [4];
   ptad_pkg::vec3_type        tc_ff;
   logic                      dgc_ff;
   logic                      dv4_ff;
   logic [61:0]                cmag_in;
   logic [31:0]                cq_in;
   logic signed [31:0]        cpt_in;
   logic signed [31:0]        cpt_ff;
   ptad_pkg::ac_side_type     as_in;
   ptad_pkg::ac_side_type     as_ff;

   logic                      av;
   logic [31:0]               ang;
   ptad_pkg::ac_side_type     aside;
   logic                      mv_ff;
   logic [54:0]               mul_ff;
   ptad_pkg::ac_side_type     mside_ff;
   logic [54:0]               rnd_in;
   logic [23:0]               dist_in;

   logic                      rsp_valid_ff;
   logic [23:0]               distance_ff;
   logic                      within_ff;
   ptad_pkg::vec3_type        nearest_ff;
   logic                      degen_ff;

   // the whole pipeline moves unless a finished transaction is held
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= ptad_pkg::RADIUS_RESET;
      end else if (csr_wr_en) begin
         radius_ff <= csr_wr_data;
      end
   end

   assign q_in.p = {req_point_z, req_point_y, req_point_x};
   assign q_in.a = {req_start_z, req_start_y, req_start_x};
   assign q_in.b = {req_end_z, req_end_y, req_end_x};

   ptad_unit_cross #(
      .FRACTION_BITS (FRACTION_BITS),
      .SIDE_W        ($bits(ptad_pkg::query_type))
   ) u_cross_g (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .a        (q_in.a),
      .b        (q_in.b),
      .in_side  (q_in),
      .out_valid(v1),
      .u        (g1),
      .zero     (z1),
      .out_side (s1)
   );

   assign s2_in.q     = s1;
   assign s2_in.g     = g1;
   assign s2_in.degen = z1;

   ptad_unit_cross #(
      .FRACTION_BITS (FRACTION_BITS),
      .SIDE_W        ($bits(ptad_pkg::stage2_side_type))
   ) u_cross_f (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v1),
      .a        (s1.p),
      .b        (g1),
      .in_side  (s2_in),
      .out_valid(v2),
      .u        (f2),
      .zero     (z2),
      .out_side (s2)
   );

   assign s3_in.q     = s2.q;
   assign s3_in.degen = s2.degen | z2;

   ptad_unit_cross #(
      .FRACTION_BITS (FRACTION_BITS),
      .SIDE_W        ($bits(ptad_pkg::stage3_side_type))
   ) u_cross_t (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v2),
      .a        (s2.g),
      .b        (f2),
      .in_side  (s3_in),
      .out_valid(v3),
      .u        (t3),
      .zero     (z3),
      .out_side (s3)
   );

   // dot products: point.t, t.start, t.end, start.end
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dp_in[i]     = $signed(s3.q.p[i]) * $signed(t3[i]);
         dp_in[3 + i] = $signed(t3[i]) * $signed(s3.q.a[i]);
         dp_in[6 + i] = $signed(t3[i]) * $signed(s3.q.b[i]);
         dp_in[9 + i] = $signed(s3.q.a[i]) * $signed(s3.q.b[i]);
      end
      for (int k = 0; k < 4; k++) begin
         if (ds_ff[k] > DOT_LIM) begin
            dc_in[k] = DOT_LIM[61:0];
         end else if (ds_ff[k] < -DOT_LIM) begin
            dc_in[k] = 62'(-DOT_LIM);
         end else begin
            dc_in[k] = ds_ff[k][61:0];
         end
      end
      // cosine truncated toward zero
      cmag_in = dc_ff[0][61] ? 62'(-dc_ff[0]) : 62'(dc_ff[0]);
      cq_in   = 32'(cmag_in >> FRACTION_BITS);
      cpt_in  = dc_ff[0][61] ? -cq_in : cq_in;
      as_in.t      = tc_ff;
      as_in.on_arc = (dc_ff[3] < dc_ff[1]) && (dc_ff[3] < dc_ff[2]);
      as_in.degen  = dgc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv1_ff <= 1'b0;
         dv2_ff <= 1'b0;
         dv3_ff <= 1'b0;
         dv4_ff <= 1'b0;
      end else if (en) begin
         dv1_ff <= v3;
         dv2_ff <= dv1_ff;
         dv3_ff <= dv2_ff;
         dv4_ff <= dv3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dp_ff  <= dp_in;
         t1_ff  <= t3;
         dg1_ff <= s3.degen | z3;
         for (int k = 0; k < 4; k++) begin
            ds_ff[k] <= 66'(dp_ff[3*k]) + 66'(dp_ff[3*k+1]) + 66'(dp_ff[3*k+2]);
         end
         t2_ff  <= t1_ff;
         dg2_ff <= dg1_ff;
         dc_ff  <= dc_in;
         tc_ff  <= t2_ff;
         dgc_ff <= dg2_ff;
         cpt_ff <= cpt_in;
         as_ff  <= as_in;
      end
   end

   ptad_arccos #(
      .FRACTION_BITS (FRACTION_BITS),
      .SIDE_W        ($bits(ptad_pkg::ac_side_type))
   ) u_arccos (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (dv4_ff),
      .cosine   (cpt_ff),
      .in_side  (as_ff),
      .out_valid(av),
      .angle    (ang),
      .out_side (aside)
   );

   always_comb begin
      rnd_in = mul_ff + (55'd1 << 29);
      if (rnd_in[54:30] > 25'(ptad_pkg::DIST_MAX)) begin
         dist_in = ptad_pkg::DIST_MAX;
      end else begin
         dist_in = rnd_in[53:30];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         mv_ff        <= av;
         rsp_valid_ff <= mv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mul_ff   <= ang * radius_ff;
         mside_ff <= aside;
         if (mside_ff.degen) begin
            distance_ff <= '0;
            within_ff   <= 1'b0;
            nearest_ff  <= '0;
         end else begin
            distance_ff <= dist_in;
            within_ff   <= mside_ff.on_arc;
            nearest_ff  <= mside_ff.t;
         end
         degen_ff <= mside_ff.degen;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_distance       = distance_ff;
   assign rsp_within_segment = within_ff;
   assign rsp_nearest_x      = nearest_ff[0];
   assign rsp_nearest_y      = nearest_ff[1];
   assign rsp_nearest_z      = nearest_ff[2];
   assign rsp_degenerate     = degen_ff;

endmodule

@@ hw/rtl/ptad_checker.sv @@
`timescale 1ns / 1ps
module ptad_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [23:0]        rsp_distance,
   input logic               rsp_within_segment,
   input logic signed [31:0] rsp_nearest_x,
   input logic signed [31:0] rsp_nearest_y,
   input logic signed [31:0] rsp_nearest_z,
   input logic               rsp_degenerate
);

   // a degenerate transaction carries all-zero results
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
         (rsp_distance == '0 && !rsp_within_segment && rsp_nearest_x == '0
          && rsp_nearest_y == '0 && rsp_nearest_z == '0))
      else $error("degenerate result with nonzero fields");

   // requests stall exactly while a result is held
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall does not follow held result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_distance)
         && $stable(rsp_within_segment) && $stable(rsp_nearest_x)
         && $stable(rsp_nearest_y) && $stable(rsp_nearest_z)
         && $stable(rsp_degenerate)))
      else $error("stalled result changed");

endmodule

bind point_to_arc_distance ptad_checker u_ptad_checker (.*);

@@ dv/tb_point_to_arc_distance.sv @@
`timescale 1ns / 1ps
module tb_point_to_arc_distance;

   localparam int      FB          = 30;
   localparam longint  ONE         = 64'sd1 << FB;
   localparam int      MAX_LATENCY = 320;
   localparam longint  CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic [23:0]        distance;
      logic               on_arc;
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [31:0] nz;
      logic               degen;
   } arc_result_type;

   typedef longint vec_type [3];

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic signed [31:0] req_point_z = '0;
   logic signed [31:0] req_start_x = '0;
   logic signed [31:0] req_start_y = '0;
   logic signed [31:0] req_start_z = '0;
   logic signed [31:0] req_end_x = '0;
   logic signed [31:0] req_end_y = '0;
   logic signed [31:0] req_end_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [23:0]        rsp_distance;
   logic               rsp_within_segment;
   logic signed [31:0] rsp_nearest_x;
   logic signed [31:0] rsp_nearest_y;
   logic signed [31:0] rsp_nearest_z;
   logic               rsp_degenerate;
   logic               csr_wr_en = 1'b0;
   logic [22:0]        csr_wr_data = '0;

   arc_result_type     expected_arcs[$];
   longint unsigned    radius_model = ptad_pkg::RADIUS_RESET;
   int                 mismatches = 0;
   longint             cycle_count = 0;

   point_to_arc_distance #(.FRACTION_BITS(FB)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_point_x(req_point_x), .req_point_y(req_point_y), .req_point_z(req_point_z),
      .req_start_x(req_start_x), .req_start_y(req_start_y), .req_start_z(req_start_z),
      .req_end_x(req_end_x), .req_end_y(req_end_y), .req_end_z(req_end_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_distance(rsp_distance), .rsp_within_segment(rsp_within_segment),
      .rsp_nearest_x(rsp_nearest_x), .rsp_nearest_y(rsp_nearest_y),
      .rsp_nearest_z(rsp_nearest_z), .rsp_degenerate(rsp_degenerate),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------- arc math ----------------

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // normalized cross product; returns 0 when the cross product is zero
   function automatic bit unit_cross(input vec_type a, input vec_type b, output vec_type u);
      longint          c[3];
      longint unsigned m[3];
      longint unsigned big;
      longint unsigned sum;
      longint unsigned n;
      longint unsigned q;
      int              rs;
      int              ls;
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
      big = 0;
      sum = 0;
      rs = 0;
      ls = 0;
      u = '{0, 0, 0};
      for (int i = 0; i < 3; i++) begin
         m[i] = c[i] < 0 ? longint'(-c[i]) : longint'(c[i]);
         if (m[i] > big) big = m[i];
      end
      if (big == 0) return 1'b0;
      while (big >= (64'd1 << 30)) begin
         big = big >> 1;
         rs++;
      end
      while (big < (64'd1 << 29)) begin
         big = big << 1;
         ls++;
      end
      for (int i = 0; i < 3; i++) begin
         m[i] = (m[i] >> rs) << ls;
         sum = sum + m[i] * m[i];
      end
      n = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << FB) + n / 2) / n;
         u[i] = c[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1'b1;
   endfunction

   function automatic longint dot_clamped(input vec_type a, input vec_type b);
      longint lim;
      longint t;
      lim = 64'sd1 << (2 * FB);
      t = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
      if (t > lim) t = lim;
      if (t < -lim) t = -lim;
      return t;
   endfunction

   function automatic longint arccos_angle(longint c);
      longint a;
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      a = c < 0 ? -c : c;
      x = a <<< (30 - FB);
      y = longint'(int_sqrt((64'd1 << (2 * FB)) - a * a)) <<< (30 - FB);
      z = 0;
      for (int i = 0; i < ptad_pkg::CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + longint'(ptad_pkg::ATAN_TABLE[i]);
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - longint'(ptad_pkg::ATAN_TABLE[i]);
         end
      end
      if (z < 0) z = 0;
      if (z > longint'(ptad_pkg::ANG_HALF_PI)) z = longint'(ptad_pkg::ANG_HALF_PI);
      return c < 0 ? longint'(ptad_pkg::ANG_PI) - z : z;
   endfunction

   function automatic arc_result_type predict_arc(input vec_type p, input vec_type a,
                                                   input vec_type b);
      arc_result_type  r;
      vec_type         g;
      vec_type         f;
      vec_type         t;
      longint          cpt;
      longint          cab;
      longint          cta;
      longint          ctb;
      longint unsigned d;
      r = '0;
      if (!unit_cross(a, b, g) || !unit_cross(p, g, f) || !unit_cross(g, f, t)) begin
         r.degen = 1'b1;
         return r;
      end
      cpt = dot_clamped(p, t) / ONE;
      d = (longint'(arccos_angle(cpt)) * radius_model + (64'd1 << 29)) >> 30;
      if (d > ptad_pkg::DIST_MAX) d = ptad_pkg::DIST_MAX;
      cta = dot_clamped(t, a);
      ctb = dot_clamped(t, b);
      cab = dot_clamped(a, b);
      r.distance = d[23:0];
      r.on_arc = (cab < cta) && (cab < ctb);
      r.nx = t[0][31:0];
      r.ny = t[1][31:0];
      r.nz = t[2][31:0];
      return r;
   endfunction

   // ---------------- stimulus helpers ----------------

   task automatic send_query(input vec_type p, input vec_type a, input vec_type b);
      arc_result_type exp_arc;
      exp_arc = predict_arc(p, a, b);
      req_valid <= 1'b1;
      req_point_x <= p[0];
      req_point_y <= p[1];
      req_point_z <= p[2];
      req_start_x <= a[0];
      req_start_y <= a[1];
      req_start_z <= a[2];
      req_end_x <= b[0];
      req_end_y <= b[1];
      req_end_z <= b[2];
      do @(posedge clock); while (req_stall);
      expected_arcs = {expected_arcs, exp_arc};
   endtask

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // callers have already dropped req_valid
   task automatic wait_drained();
      @(posedge clock);
      while (expected_arcs.size() != 0) @(posedge clock);
   endtask

   task automatic write_radius(input logic [22:0] value);
      wait_drained();
      repeat (MAX_LATENCY) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      radius_model = value;
      csr_wr_en <= 1'b0;
   endtask

   function automatic vec_type make_vec(longint x, longint y, longint z);
      vec_type v;
      v = '{x, y, z};
      return v;
   endfunction

   function automatic longint clamp_comp(longint v);
      if (v > ONE) return ONE;
      if (v < -ONE) return -ONE;
      return v;
   endfunction

   function automatic vec_type rand_unit();
      real x;
      real y;
      real z;
      real n;
      do begin
         x = real'($urandom_range(0, 2000000)) - 1000000.0;
         y = real'($urandom_range(0, 2000000)) - 1000000.0;
         z = real'($urandom_range(0, 2000000)) - 1000000.0;
         n = $sqrt(x * x + y * y + z * z);
      end while (n < 1.0);
      return make_vec(clamp_comp($rtoi(x / n * 1073741824.0)),
                      clamp_comp($rtoi(y / n * 1073741824.0)),
                      clamp_comp($rtoi(z / n * 1073741824.0)));
   endfunction

   // a unit vector close to v, for short segments and points near the circle
   function automatic vec_type near_unit(input vec_type v, int spread);
      real    x;
      real    y;
      real    z;
      real    n;
      x = real'(v[0]) + real'($urandom_range(0, 2 * spread)) - real'(spread);
      y = real'(v[1]) + real'($urandom_range(0, 2 * spread)) - real'(spread);
      z = real'(v[2]) + real'($urandom_range(0, 2 * spread)) - real'(spread);
      n = $sqrt(x * x + y * y + z * z);
      if (n < 1.0) return v;
      return make_vec(clamp_comp($rtoi(x / n * 1073741824.0)),
                      clamp_comp($rtoi(y / n * 1073741824.0)),
                      clamp_comp($rtoi(z / n * 1073741824.0)));
   endfunction

   function automatic vec_type rand_raw();
      return make_vec(longint'($urandom_range(0, 32'h80000000)) - ONE,
                      longint'($urandom_range(0, 32'h80000000)) - ONE,
                      longint'($urandom_range(0, 32'h80000000)) - ONE);
   endfunction

   task automatic send_random_query();
      vec_type p;
      vec_type a;
      vec_type b;
      int      pick;
      pick = $urandom_range(0, 99);
      a = rand_unit();
      if (pick < 45) begin
         b = rand_unit();
         p = rand_unit();
      end else if (pick < 65) begin
         b = near_unit(a, $urandom_range(1000, 100000000));
         p = near_unit(a, $urandom_range(1000, 400000000));
      end else if (pick < 75) begin
         b = rand_unit();
         p = near_unit(b, $urandom_range(1, 1000));
      end else if (pick < 82) begin
         // degenerate: equal or opposite ends
         if ($urandom_range(0, 1) == 0) begin
            b = a;
         end else begin
            b = make_vec(-a[0], -a[1], -a[2]);
         end
         p = rand_unit();
      end else begin
         a = rand_raw();
         b = rand_raw();
         p = rand_raw();
      end
      send_query(p, a, b);
   endtask

   task automatic run_random(input int count);
      int burst;
      int sent;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && sent < count; i++) begin
            send_random_query();
            sent++;
         end
         if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
      end
      req_valid <= 1'b0;
   endtask

   // ---------------- tests ----------------

   task automatic test_directed();
      vec_type ex;
      vec_type ey;
      vec_type ez;
      vec_type nx;
      vec_type ny;
      vec_type nz;
      vec_type mid;
      ex = make_vec(ONE, 0, 0);
      ey = make_vec(0, ONE, 0);
      ez = make_vec(0, 0, ONE);
      nx = make_vec(-ONE, 0, 0);
      ny = make_vec(0, -ONE, 0);
      nz = make_vec(0, 0, -ONE);
      mid = make_vec(759250125, 759250125, 0);
      send_query(mid, ex, ey);
      send_query(ex, ex, ey);
      send_query(ey, ex, ey);
      send_query(ny, ex, ey);
      send_query(make_vec(0, 759250125, 759250125), ex, ey);
      send_query(make_vec(-759250125, 0, -759250125), ex, ey);
      send_query(nx, ny, nz);
      // point on the pole of the circle: second cross product vanishes
      send_query(ez, ex, ey);
      send_query(nz, ex, ey);
      // equal and opposite ends
      send_query(ey, ex, ex);
      send_query(ey, ex, nx);
      send_query(make_vec(0, 0, 0), ex, ey);
      send_query(ex, make_vec(0, 0, 0), ey);
      // full-range magnitudes, not of unit length
      send_query(make_vec(-ONE, -ONE, -ONE), make_vec(ONE, -ONE, ONE), make_vec(ONE, ONE, -ONE));
      send_query(make_vec(ONE, ONE, ONE), make_vec(-ONE, ONE, ONE), make_vec(1, 0, 0));
      send_query(make_vec(ONE - 1, -ONE + 1, 1), make_vec(-1, 1, -1), make_vec(1, -1, -1));
      send_query(nx, ex, ey);
      send_query(near_unit(mid, 50), ex, near_unit(ex, 20000));
      req_valid <= 1'b0;
   endtask

   task automatic test_radius_extremes();
      logic [22:0] radii [4];
      radii = '{23'd1, 23'd8388607, 23'd0, ptad_pkg::RADIUS_RESET};
      foreach (radii[i]) begin
         write_radius(radii[i]);
         run_random(40);
      end
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 4; phase++) begin
         write_radius(23'($urandom_range(1, 8388607)));
         run_random(200);
      end
   endtask

   task automatic test_drain_pause();
      run_random(60);
      wait_drained();
      run_random(60);
   endtask

   // ---------------- result side ----------------

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      case ((cycle_count >> 9) % 4)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ((cycle_count % 64) < 20);
      endcase
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_point_to_arc_distance: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      arc_result_type want;
      arc_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_distance, rsp_within_segment, rsp_nearest_x, rsp_nearest_y,
                 rsp_nearest_z, rsp_degenerate};
         if (expected_arcs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction: %p", got);
         end else begin
            want = expected_arcs.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_radius_extremes();
      test_drain_pause();
      test_random();
      wait_drained();
      repeat (MAX_LATENCY) @(posedge clock);
      if (mismatches == 0 && expected_arcs.size() == 0)
         $display("tb_point_to_arc_distance: done, clean");
      else
         $display("tb_point_to_arc_distance: done, errors");
      $finish;
   end

endmodule
